[rtl/core/escd_pkg.sv]
// ----------------------------------------------------------------------------
// escd_pkg
// Types, character codes and helper functions shared by the escape decoder.
// ----------------------------------------------------------------------------
package escd_pkg;

   // Character codes
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_QMARK  = 8'h3F;
   localparam logic [7:0] CHAR_LBRACK = 8'h5B;
   localparam logic [7:0] CHAR_RBRACK = 8'h5D;

   // Decode mode, one-hot
   typedef enum logic [4:0] {
      MODE_NORMAL  = 5'b00001,
      MODE_ESCAPED = 5'b00010,
      MODE_HEX_HI  = 5'b00100,
      MODE_HEX_LO  = 5'b01000,
      MODE_DISCARD = 5'b10000
   } mode_type;

   // One result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_error;
      logic       run_last;
      logic       text_end;
   } result_type;

   // Outcome of decoding one input byte
   typedef struct packed {
      result_type res0;
      result_type res1;
      logic [1:0] res_cnt;
      mode_type   mode;
      logic [3:0] nibble;
   } step_type;

   // Hex digit decode: bit 4 set means valid, bits 3:0 the value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic is_glob(input logic [7:0] c);
      return (c == CHAR_STAR) || (c == CHAR_QMARK) || (c == CHAR_LBRACK) ||
             (c == CHAR_RBRACK) || (c == CHAR_BSLASH);
   endfunction

endpackage

[rtl/core/escd_step.sv]
// ----------------------------------------------------------------------------
// escd_step
// Decodes one text byte against the current mode: gives zero to two results
// and the next mode and saved high nibble.
// ----------------------------------------------------------------------------
module escd_step
   import escd_pkg::*;
(
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       quote_glob,
   input  mode_type   mode,
   input  logic [3:0] nibble,
   output step_type   step
);

   logic [4:0]  hex;
   result_type  r0;
   result_type  r1;
   logic [1:0]  n;
   mode_type    mode_n;
   logic [3:0]  nib_n;

   assign hex = hex_decode(in_byte);

   always_comb begin
      r0     = '0;
      r1     = '0;
      n      = 2'd0;
      mode_n = mode;
      nib_n  = nibble;

      // Main decode per mode
      case (mode)
         MODE_NORMAL: begin
            if (in_byte == CHAR_BSLASH) begin
               mode_n = MODE_ESCAPED;
            end else begin
               r0.out_byte  = in_byte;
               r0.out_valid = 1'b1;
               n            = 2'd1;
            end
         end
         MODE_ESCAPED: begin
            if (in_byte == CHAR_X) begin
               mode_n = MODE_HEX_HI;
            end else begin
               mode_n = MODE_NORMAL;
               if (quote_glob && is_glob(in_byte)) begin
                  r0.out_byte  = CHAR_BSLASH;
                  r0.out_valid = 1'b1;
                  r1.out_byte  = in_byte;
                  r1.out_valid = 1'b1;
                  n            = 2'd2;
               end else begin
                  r0.out_byte  = in_byte;
                  r0.out_valid = 1'b1;
                  n            = 2'd1;
               end
            end
         end
         MODE_HEX_HI: begin
            if (hex[4]) begin
               nib_n  = hex[3:0];
               mode_n = MODE_HEX_LO;
            end else begin
               r0.out_error = 1'b1;
               n            = 2'd1;
               mode_n       = MODE_DISCARD;
            end
         end
         MODE_HEX_LO: begin
            nib_n = 4'd0;
            n     = 2'd1;
            if (hex[4]) begin
               r0.out_byte  = {nibble, hex[3:0]};
               r0.out_valid = 1'b1;
               mode_n       = MODE_NORMAL;
            end else begin
               r0.out_error = 1'b1;
               mode_n       = MODE_DISCARD;
            end
         end
         default: begin
            mode_n = MODE_DISCARD;
         end
      endcase

      // End of text: force one result, flag it, return to normal
      if (in_last) begin
         if (n == 2'd0) begin
            r0.out_error = (mode_n == MODE_HEX_HI) || (mode_n == MODE_HEX_LO);
            n            = 2'd1;
         end
         if (n == 2'd2) begin
            r1.text_end = 1'b1;
         end else begin
            r0.text_end = 1'b1;
         end
         mode_n = MODE_NORMAL;
         nib_n  = 4'd0;
      end

      // Mark the last result of this byte
      if (n == 2'd2) begin
         r1.run_last = 1'b1;
      end else if (n == 2'd1) begin
         r0.run_last = 1'b1;
      end
   end

   assign step.res0    = r0;
   assign step.res1    = r1;
   assign step.res_cnt = n;
   assign step.mode    = mode_n;
   assign step.nibble  = nib_n;

endmodule

[rtl/core/shell_escape_decoder.sv]
// ----------------------------------------------------------------------------
// shell_escape_decoder
// Results are registered in the result queue and driven on rsp from its head.
// Throughput: one byte per cycle while two queue entries are free; a byte giving
//   two results (escaped glob character with quoting on) takes two entries of
//   the three-entry result queue, which the single result port drains.
// Reset (synchronous): mode normal, nibble zero, quote_glob off, queue empty.
// ----------------------------------------------------------------------------
module shell_escape_decoder
   import escd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   // Result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [0] out_valid, [1] out_error, [2] run_last
   output logic       rsp_tlast,   // text_end
   // Configuration
   input  logic       csr_we,
   input  logic       csr_wdata    // quote_glob
);

   localparam int QDEPTH = 3;

   logic        glob_ff;
   mode_type    mode_ff;
   logic [3:0]  nibble_ff;
   result_type  q_ff [QDEPTH];
   result_type  q_in [QDEPTH];
   logic [1:0]  cnt_ff;
   logic [1:0]  cnt_in;
   logic [1:0]  base;
   logic        push;
   logic        pop;
   step_type    step;

   // Decode the incoming byte
   escd_step u_step (
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .quote_glob(glob_ff),
      .mode      (mode_ff),
      .nibble    (nibble_ff),
      .step      (step)
   );

   // Take a byte while two queue entries are free
   assign req_tready = (cnt_ff < 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;

   // Drive the head of the queue
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = q_ff[0].out_byte;
   assign rsp_tuser  = {q_ff[0].run_last, q_ff[0].out_error, q_ff[0].out_valid};
   assign rsp_tlast  = q_ff[0].text_end;

   // Shift out the head, then append new results
   always_comb begin
      base    = cnt_ff - 2'(pop);
      q_in[0] = pop ? q_ff[1] : q_ff[0];
      q_in[1] = pop ? q_ff[2] : q_ff[1];
      q_in[2] = q_ff[2];
      for (int i = 0; i < QDEPTH; i++) begin
         if (push && base == 2'(i)) begin
            q_in[i] = step.res0;
         end
         if (push && step.res_cnt == 2'd2 && base + 2'd1 == 2'(i)) begin
            q_in[i] = step.res1;
         end
      end
      cnt_in = base + (push ? step.res_cnt : 2'd0);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         glob_ff   <= 1'b0;
         mode_ff   <= MODE_NORMAL;
         nibble_ff <= 4'd0;
         cnt_ff    <= 2'd0;
      end else begin
         if (csr_we) begin
            glob_ff <= csr_wdata;
         end
         if (push) begin
            mode_ff   <= step.mode;
            nibble_ff <= step.nibble;
         end
         cnt_ff <= cnt_in;
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // Checks
   a_last_resets_mode: assert property (@(posedge clock) disable iff (reset)
      (push && req_tlast) |=> (mode_ff == MODE_NORMAL && nibble_ff == 4'd0))
      else $error("mode not cleared after final byte");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (push && req_tlast) |-> (step.res_cnt != 2'd0))
      else $error("final byte produced no result");

   a_error_is_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (!rsp_tuser[0] && rsp_tdata == 8'd0))
      else $error("error result carries a byte");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[2])
      else $error("text end not on last result of its byte");

endmodule

[bench/escd_checker.sv]
// ----------------------------------------------------------------------------
// escd_checker
// Watches the byte and result streams of the escape decoder and keeps its own
// decoder state. Every byte transfer yields the results it should cause, and
// every result transfer is compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module escd_checker
   import escd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [2:0] rsp_tuser,
   input  logic       rsp_tlast,
   input  logic       csr_we,
   input  logic       csr_wdata,
   output int         fail_count,
   output int         pending,
   output int         result_count,
   output int         error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Decoder state as the block should hold it
   mode_type   dec_mode;
   logic [3:0] hi_nibble;
   logic       glob_on;

   // Results still owed by the block, oldest first
   result_type unquoted_q [$];

   // Value of a hex digit in either case, -1 for any other byte
   function automatic int digit_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   function automatic logic glob_special(input logic [7:0] c);
      case (c)
         CHAR_STAR, CHAR_QMARK, CHAR_LBRACK, CHAR_RBRACK, CHAR_BSLASH: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic result_type make_result(input logic [7:0] b, input logic valid,
                                              input logic err);
      result_type r;
      r = '0;
      r.out_byte  = b;
      r.out_valid = valid;
      r.out_error = err;
      return r;
   endfunction

   // Advance the decoder by one byte and queue the results it causes
   function automatic void decode_byte(input logic [7:0] c, input logic last);
      result_type res [2];
      int         n;
      int         v;
      n = 0;
      res[0] = '0;
      res[1] = '0;
      case (dec_mode)
         MODE_NORMAL: begin
            if (c == CHAR_BSLASH) begin
               dec_mode = MODE_ESCAPED;
            end else begin
               res[n] = make_result(c, 1'b1, 1'b0);
               n++;
            end
         end
         MODE_ESCAPED: begin
            if (c == CHAR_X) begin
               dec_mode = MODE_HEX_HI;
            end else begin
               // glob mode keeps the backslash in front of a glob character
               if (glob_on && glob_special(c)) begin
                  res[n] = make_result(CHAR_BSLASH, 1'b1, 1'b0);
                  n++;
               end
               res[n] = make_result(c, 1'b1, 1'b0);
               n++;
               dec_mode = MODE_NORMAL;
            end
         end
         MODE_HEX_HI: begin
            v = digit_value(c);
            if (v >= 0) begin
               hi_nibble = v[3:0];
               dec_mode  = MODE_HEX_LO;
            end else begin
               res[n] = make_result(8'h00, 1'b0, 1'b1);
               n++;
               dec_mode = MODE_DISCARD;
            end
         end
         MODE_HEX_LO: begin
            v = digit_value(c);
            if (v >= 0) begin
               res[n] = make_result({hi_nibble, v[3:0]}, 1'b1, 1'b0);
               n++;
               dec_mode = MODE_NORMAL;
            end else begin
               res[n] = make_result(8'h00, 1'b0, 1'b1);
               n++;
               dec_mode = MODE_DISCARD;
            end
            hi_nibble = 4'h0;
         end
         default: begin
            dec_mode = MODE_DISCARD;
         end
      endcase

      // Close the text: an unfinished hex escape is an error, else a bare marker
      if (last) begin
         if (n == 0) begin
            if (dec_mode == MODE_HEX_HI || dec_mode == MODE_HEX_LO) begin
               res[n] = make_result(8'h00, 1'b0, 1'b1);
            end else begin
               res[n] = make_result(8'h00, 1'b0, 1'b0);
            end
            n++;
         end
         res[n-1].text_end = 1'b1;
         dec_mode  = MODE_NORMAL;
         hi_nibble = 4'h0;
      end
      if (n > 0) begin
         res[n-1].run_last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         unquoted_q.push_back(res[i]);
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Track configuration, predict on byte transfers, compare on result transfers
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         dec_mode  = MODE_NORMAL;
         hi_nibble = 4'h0;
         glob_on   = 1'b0;
         unquoted_q.delete();
      end else begin
         if (csr_we) begin
            glob_on = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (unquoted_q.size() == 0) begin
               $error("result transfer with nothing expected: tdata %h tuser %b tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = unquoted_q.pop_front();
               if (want.out_error) error_count++;
               check_field("out_byte",  want.out_byte,  rsp_tdata);
               check_field("out_valid", 8'(want.out_valid), 8'(rsp_tuser[0]));
               check_field("out_error", 8'(want.out_error), 8'(rsp_tuser[1]));
               check_field("run_last",  8'(want.run_last),  8'(rsp_tuser[2]));
               check_field("text_end",  8'(want.text_end),  8'(rsp_tlast));
            end
         end
      end
      pending <= unquoted_q.size();
   end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the escape decoder: directed texts covering hex escapes, glob
// quoting, bad and truncated hex and a trailing backslash, then random texts
// under changing idle rates and glob settings, with one long receiver stall.
// ----------------------------------------------------------------------------
module tb_top
   import escd_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_we     = 1'b0;
   logic       csr_wdata  = 1'b0;

   int fail_count;
   int pending;
   int result_count;
   int error_count;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_off_req = 1'b0;
   int bytes_sent = 0;
   int texts_sent = 0;

   shell_escape_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   escd_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .result_count (result_count),
      .error_count  (error_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      #2_000_000;
      $display("Timeout: results still pending %0d", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: random backpressure, or one long hold-off when requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            for (int i = 0; i < 300; i++) begin
               @(posedge clock);
            end
            hold_off_req = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offer one byte, idling first at random, and hold it until transferred
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (last) texts_sent++;
   endtask

   task automatic send_string(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], close && (i == s.len() - 1));
      end
   endtask

   // Change the glob setting once the decoder has drained
   task automatic write_glob(input logic v);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
      if (n < 10) return 8'h30 + n;
      return (upper ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   // Random byte that is not a hex digit: setting bit 7 rules out every digit
   function automatic logic [7:0] non_hex_char();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
          (b >= 8'h61 && b <= 8'h66)) begin
         b = b | 8'h80;
      end
      return b;
   endfunction

   // Build one random text, mostly well-formed escapes, and send it
   task automatic send_random_text();
      logic [7:0] text_q [$];
      logic [7:0] b;
      int         tokens;
      int         r;
      tokens = $urandom_range(1, 8);
      for (int t = 0; t < tokens; t++) begin
         r = $urandom_range(99);
         if (r < 35) begin
            b = 8'($urandom_range(255));
            if (b == CHAR_BSLASH) b = ~b;
            text_q.push_back(b);
         end else if (r < 50) begin
            b = 8'($urandom_range(255));
            if (b == CHAR_X) b = 8'h58;
            text_q.push_back(CHAR_BSLASH);
            text_q.push_back(b);
         end else if (r < 65) begin
            case ($urandom_range(4))
               0: b = CHAR_STAR;
               1: b = CHAR_QMARK;
               2: b = CHAR_LBRACK;
               3: b = CHAR_RBRACK;
               default: b = CHAR_BSLASH;
            endcase
            text_q.push_back(CHAR_BSLASH);
            text_q.push_back(b);
         end else if (r < 88) begin
            text_q.push_back(CHAR_BSLASH);
            text_q.push_back(CHAR_X);
            text_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            text_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
         end else if (r < 94) begin
            // broken hex escape; the rest of the text is discarded
            text_q.push_back(CHAR_BSLASH);
            text_q.push_back(CHAR_X);
            if ($urandom_range(1)) text_q.push_back(hex_char(4'($urandom_range(15)), 1'b0));
            text_q.push_back(non_hex_char());
         end else begin
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(255)));
         end
      end

      // Sometimes end the text inside an escape
      r = $urandom_range(99);
      if (r < 8) begin
         text_q.push_back(CHAR_BSLASH);
         text_q.push_back(CHAR_X);
      end else if (r < 16) begin
         text_q.push_back(CHAR_BSLASH);
         text_q.push_back(CHAR_X);
         text_q.push_back(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
      end else if (r < 22) begin
         text_q.push_back(CHAR_BSLASH);
      end

      for (int i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
      end
   endtask

   task automatic run_random(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) send_random_text();
   endtask

   // Main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, glob quoting off: byte extremes, hex both cases, bad and
      // truncated hex, discarded tail, lone trailing backslash
      write_glob(1'b0);
      send_byte(8'h00, 1'b0);
      send_string("\\x4F\\xa0", 1'b0);
      send_byte(8'hFF, 1'b1);
      send_string("\\xgz", 1'b1);
      send_string("\\x3", 1'b1);
      send_string("\\", 1'b1);

      // Directed, glob quoting on: kept backslash, plain escape, bad first hex digit
      write_glob(1'b1);
      send_string("\\[\\\\\\n", 1'b1);
      send_string("\\xZ", 1'b1);

      // Random: sender rarely idle, receiver often idle
      tx_idle_pct = 7;
      rx_idle_pct = 51;
      run_random(330);

      // Random: the other way round, glob quoting off
      write_glob(1'b0);
      tx_idle_pct = 51;
      rx_idle_pct = 7;
      run_random(330);

      // Random: no idling, with one long receiver hold-off to fill the block
      write_glob(1'b1);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_off_req = 1'b1;
      run_random(340);

      // Drain
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d texts, %0d bytes, glob quoting off and on, with idle and stall",
               texts_sent, bytes_sent);
      $display("Checked %0d results, %0d of them hex errors", result_count, error_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[shell_escape_decoder.f]
rtl/core/escd_pkg.sv
rtl/core/escd_step.sv
rtl/core/shell_escape_decoder.sv
bench/escd_checker.sv
bench/tb_top.sv
